// ----- rtl/first_fit_block_allocator_core_defines.svh -----
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset
`define FFBA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ffba assertion failed");
// Check that an antecedent implies a consequent in the same cycle
`define FFBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffba implication failed");
`else
`define FFBA_ASSERT(label, prop)
`define FFBA_ASSERT_IMP(label, ante, cons)
`endif

`endif

// ----- rtl/ffba_pkg.sv -----
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;

    localparam logic [31:0] HEAP_BASE_RST  = 32'h0000_1000;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [31:0] SIZE_CAP       = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2,
        OP_CALLOC  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_UNKNOWN  = 3'd4
    } status_t;

    localparam logic [1:0] CFG_HEAP_BASE  = 2'd0;
    localparam logic [1:0] CFG_HEAP_LIMIT = 2'd1;

    typedef struct packed {
        logic        free;
        logic [30:0] size;
        logic [31:0] addr;
    } entry_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] result_address;
        logic [30:0] copy_bytes;
        logic [31:0] released_address;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/ffba_table.sv -----
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_table
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    localparam int IDXW = $clog2(MAX_BLOCKS)
)
(
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [IDXW-1:0] rd_idx,
    output entry_t               rd_data,
    input  wire logic            wr_en,
    input  wire logic [IDXW-1:0] wr_idx,
    input  wire entry_t          wr_data
);

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ffba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: table scan with one shared compare, bump append and
// element-count multiply, one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    localparam int IDXW = $clog2(MAX_BLOCKS),
    localparam int CNTW = $clog2(MAX_BLOCKS + 1)
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire op_t             in_op,
    input  wire logic [30:0]     in_size,
    input  wire logic [30:0]     in_count,
    input  wire logic [31:0]     in_baddr,
    input  wire logic            base_we,
    input  wire logic [31:0]     base_value,
    input  wire logic [31:0]     heap_limit,
    input  wire logic            out_free,
    output logic                 res_valid,
    output res_t                 res,
    output logic [CNTW-1:0]      entry_count,
    output logic                 rd_en,
    output logic [IDXW-1:0]      rd_idx,
    input  wire entry_t          rd_data,
    output logic                 wr_en,
    output logic [IDXW-1:0]      wr_idx,
    output entry_t               wr_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_MULCHK, S_SCAN, S_APPEND1, S_APPEND2, S_FREEOLD, S_DONE
    } state_t;

    typedef enum logic {
        K_ALLOC, K_LOOKUP
    } kind_t;

    state_t           state_reg,     state_next;
    op_t              op_reg,        op_next;
    kind_t            kind_reg,      kind_next;
    logic [30:0]      size_reg,      size_next;
    logic [30:0]      count_reg,     count_next;
    logic [31:0]      baddr_reg,     baddr_next;
    logic [61:0]      prod_reg,      prod_next;
    logic [CNTW-1:0]  cnt_reg,       cnt_next;
    logic             pend_reg,      pend_next;
    logic [IDXW-1:0]  pend_idx_reg,  pend_idx_next;
    logic [IDXW-1:0]  old_idx_reg,   old_idx_next;
    logic [30:0]      old_size_reg,  old_size_next;
    logic             move_reg,      move_next;
    logic [32:0]      data_reg,      data_next;
    status_t          status_reg,    status_next;
    logic [31:0]      raddr_reg,     raddr_next;
    logic [30:0]      copy_reg,      copy_next;
    logic [31:0]      rel_reg,       rel_next;
    logic [CNTW-1:0]  ecount_reg,    ecount_next;
    logic [31:0]      top_reg,       top_next;

    logic [33:0] new_top;
    logic        hit;

    assign new_top = {1'b0, data_reg} + {3'b000, size_reg};
    assign hit = (kind_reg == K_ALLOC) ? (rd_data.free && (rd_data.size >= size_reg))
                                       : (rd_data.addr == baddr_reg);

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        kind_next     = kind_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        baddr_next    = baddr_reg;
        prod_next     = prod_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        old_idx_next  = old_idx_reg;
        old_size_next = old_size_reg;
        move_next     = move_reg;
        data_next     = data_reg;
        status_next   = status_reg;
        raddr_next    = raddr_reg;
        copy_next     = copy_reg;
        rel_next      = rel_reg;
        ecount_next   = ecount_reg;
        top_next      = top_reg;
        rd_en         = 1'b0;
        rd_idx        = IDXW'(cnt_reg - 1'b1);
        wr_en         = 1'b0;
        wr_idx        = pend_idx_reg;
        wr_data       = rd_data;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = in_op;
                    size_next   = in_size;
                    count_next  = in_count;
                    baddr_next  = in_baddr;
                    move_next   = 1'b0;
                    status_next = ST_OK;
                    raddr_next  = '0;
                    copy_next   = '0;
                    rel_next    = '0;
                    cnt_next    = ecount_reg;
                    pend_next   = 1'b0;
                    kind_next   = K_ALLOC;
                    state_next  = S_SCAN;
                    unique case (in_op)
                        OP_ALLOC:
                        begin
                            if (in_size == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                        end
                        OP_FREE:
                        begin
                            kind_next = K_LOOKUP;
                            if (in_baddr == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                        end
                        OP_REALLOC:
                        begin
                            if (in_baddr != '0)
                            begin
                                kind_next = K_LOOKUP;
                            end
                            else if (in_size == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                        end
                        OP_CALLOC:
                        begin
                            if (in_count == '0 || in_size == '0)
                            begin
                                status_next = ST_ZERO;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_MUL:
            begin
                prod_next  = count_reg * size_reg;
                state_next = S_MULCHK;
            end

            S_MULCHK:
            begin
                if (prod_reg > 62'(SIZE_CAP))
                begin
                    status_next = ST_OVERFLOW;
                    state_next  = S_DONE;
                end
                else
                begin
                    size_next  = prod_reg[30:0];
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue the next older entry while checking the one read last cycle
                if (cnt_reg != '0)
                begin
                    rd_en         = 1'b1;
                    cnt_next      = cnt_reg - 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg && hit)
                begin
                    if (kind_reg == K_ALLOC)
                    begin
                        wr_en        = 1'b1;
                        wr_data.free = 1'b0;
                        raddr_next   = rd_data.addr;
                        state_next   = move_reg ? S_FREEOLD : S_DONE;
                    end
                    else if (op_reg == OP_FREE)
                    begin
                        wr_en        = 1'b1;
                        wr_data.free = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (rd_data.free)
                    begin
                        status_next = ST_UNKNOWN;
                        state_next  = S_DONE;
                    end
                    else if (size_reg == '0)
                    begin
                        wr_en        = 1'b1;
                        wr_data.free = 1'b1;
                        status_next  = ST_ZERO;
                        state_next   = S_DONE;
                    end
                    else if (rd_data.size >= size_reg)
                    begin
                        raddr_next = baddr_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // too small: remember the old block and rescan for a new one
                        old_idx_next  = pend_idx_reg;
                        old_size_next = rd_data.size;
                        move_next     = 1'b1;
                        kind_next     = K_ALLOC;
                        cnt_next      = ecount_reg;
                        pend_next     = 1'b0;
                    end
                end
                else if (!pend_reg && cnt_reg == '0)
                begin
                    if (kind_reg == K_LOOKUP)
                    begin
                        status_next = ST_UNKNOWN;
                        state_next  = S_DONE;
                    end
                    else if (ecount_reg >= CNTW'(MAX_BLOCKS))
                    begin
                        status_next = ST_NOSPACE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_APPEND1;
                    end
                end
            end

            S_APPEND1:
            begin
                data_next  = {1'b0, top_reg} + 33'(HEADER_BYTES);
                state_next = S_APPEND2;
            end

            S_APPEND2:
            begin
                if (new_top > {2'b00, heap_limit})
                begin
                    status_next = ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    wr_en        = 1'b1;
                    wr_idx       = ecount_reg[IDXW-1:0];
                    wr_data.free = 1'b0;
                    wr_data.size = size_reg;
                    wr_data.addr = data_reg[31:0];
                    ecount_next  = ecount_reg + 1'b1;
                    top_next     = new_top[31:0];
                    raddr_next   = data_reg[31:0];
                    state_next   = move_reg ? S_FREEOLD : S_DONE;
                end
            end

            S_FREEOLD:
            begin
                wr_en        = 1'b1;
                wr_idx       = old_idx_reg;
                wr_data.free = 1'b1;
                wr_data.size = old_size_reg;
                wr_data.addr = baddr_reg;
                copy_next    = old_size_reg;
                rel_next     = baddr_reg;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // heap base moves the top only while no block exists
        if (base_we && ecount_reg == '0)
        begin
            top_next = base_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_ALLOC;
            kind_reg     <= K_ALLOC;
            size_reg     <= '0;
            count_reg    <= '0;
            baddr_reg    <= '0;
            prod_reg     <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            old_idx_reg  <= '0;
            old_size_reg <= '0;
            move_reg     <= 1'b0;
            data_reg     <= '0;
            status_reg   <= ST_OK;
            raddr_reg    <= '0;
            copy_reg     <= '0;
            rel_reg      <= '0;
            ecount_reg   <= '0;
            top_reg      <= HEAP_BASE_RST;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            kind_reg     <= kind_next;
            size_reg     <= size_next;
            count_reg    <= count_next;
            baddr_reg    <= baddr_next;
            prod_reg     <= prod_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            old_idx_reg  <= old_idx_next;
            old_size_reg <= old_size_next;
            move_reg     <= move_next;
            data_reg     <= data_next;
            status_reg   <= status_next;
            raddr_reg    <= raddr_next;
            copy_reg     <= copy_next;
            rel_reg      <= rel_next;
            ecount_reg   <= ecount_next;
            top_reg      <= top_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign entry_count = ecount_reg;

    always_comb
    begin
        res.status           = status_reg;
        res.result_address   = (status_reg == ST_OK) ? raddr_reg : '0;
        res.copy_bytes       = (status_reg == ST_OK) ? copy_reg  : '0;
        res.released_address = (status_reg == ST_OK) ? rel_reg   : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/first_fit_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap block allocator with a block table and a bump top pointer.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request scans the block table from the
// newest entry to the oldest through the single table read port, one entry a
// cycle. Appending a new block adds the states S_APPEND1 and S_APPEND2, and a
// zeroed allocate (count times size) first runs S_MUL and S_MULCHK. A moving
// reallocate runs two scans. The result waits in an output register, and the
// next request is taken as soon as the sequencer is back at idle. No clearing
// pass follows reset; the table holds only entries that were written.
`default_nettype none

`include "first_fit_block_allocator_core_defines.svh"

module first_fit_block_allocator_core
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // request_size, elem_count, block_address, pad
    input  wire logic [1:0]  s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // result_address, copy_bytes, released_address, pad
    output logic [2:0]       m_axis_tuser,  // status
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int IDXW = $clog2(MAX_BLOCKS);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);

    logic            cfg_xfer;
    logic [31:0]     heap_limit_reg;
    logic            m_valid_reg;
    logic [95:0]     m_data_reg;
    logic [2:0]      m_user_reg;
    logic            out_free;
    logic            res_valid;
    res_t            res;
    logic [CNTW-1:0] entry_count;
    logic            rd_en;
    logic [IDXW-1:0] rd_idx;
    entry_t          rd_data;
    logic            wr_en;
    logic [IDXW-1:0] wr_idx;
    entry_t          wr_data;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_axis_tready;

    ffba_ctrl #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (op_t'(s_axis_tuser)),
        .in_size     (s_axis_tdata[30:0]),
        .in_count    (s_axis_tdata[61:31]),
        .in_baddr    (s_axis_tdata[93:62]),
        .base_we     (cfg_xfer && cfg_index == CFG_HEAP_BASE),
        .base_value  (cfg_data),
        .heap_limit  (heap_limit_reg),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .entry_count (entry_count),
        .rd_en       (rd_en),
        .rd_idx      (rd_idx),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_idx      (wr_idx),
        .wr_data     (wr_data)
    );

    ffba_table #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= HEAP_LIMIT_RST;
            m_valid_reg    <= 1'b0;
            m_data_reg     <= '0;
            m_user_reg     <= '0;
        end
        else
        begin
            if (cfg_xfer && cfg_index == CFG_HEAP_LIMIT)
            begin
                heap_limit_reg <= cfg_data;
            end
            // load a finished result, or drop the one just taken
            if (res_valid)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {1'b0, res.released_address, res.copy_bytes,
                                res.result_address};
                m_user_reg  <= res.status;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `FFBA_ASSERT(a_one_at_a_time, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    `FFBA_ASSERT_IMP(a_load_into_free_slot, res_valid, !m_valid_reg || m_axis_tready)
    `FFBA_ASSERT_IMP(a_count_in_range, 1'b1, entry_count <= CNTW'(MAX_BLOCKS))
    `FFBA_ASSERT(a_count_steps_by_one, (entry_count != $past(entry_count)) |-> (entry_count == $past(entry_count) + 1'b1))

endmodule

`default_nettype wire

// ----- verif/first_fit_block_allocator_core_tb.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core_tb
// Drives allocate, free, reallocate and zeroed-allocate requests through the
// stream ports and checks every result, field by field, against a block-table
// predictor kept in step with each accepted transfer. Directed requests cover
// the rejects and edge settings, then random traffic runs under several heap
// settings and idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_core_tb;

    import ffba_pkg::*;

    localparam int          TABLE_DEPTH  = MAX_BLOCKS_DEF;
    localparam int          HEADER_SIZE  = HEADER_BYTES_DEF;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          PHASE_ITEMS  = 280;
    localparam logic [1:0]  CFG_SPARE_LO = 2'd2;
    localparam logic [1:0]  CFG_SPARE_HI = 2'd3;
    localparam logic [31:0] ADDR_MAX     = 32'hFFFF_FFFF;
    localparam logic [30:0] SIZE_MAX     = 31'h7FFF_FFFF;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata  = '0;   // request_size, elem_count, block_address, pad
    logic [1:0]  s_axis_tuser  = '0;   // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;         // result_address, copy_bytes, released_address, pad
    logic [2:0]  m_axis_tuser;         // status
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = '0;
    logic [31:0] cfg_data      = '0;

    first_fit_block_allocator_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted heap state
    logic [31:0] tbl_addr [TABLE_DEPTH];
    logic [30:0] tbl_size [TABLE_DEPTH];
    bit          tbl_free [TABLE_DEPTH];
    int          tbl_used = 0;
    logic [31:0] brk_ptr  = HEAP_BASE_RST;
    logic [31:0] cfg_base = HEAP_BASE_RST;
    logic [31:0] cfg_limit = HEAP_LIMIT_RST;

    res_t        pending_results [$];
    int          errors        = 0;
    int          requests_sent = 0;
    int          settings_used = 1;
    int          status_seen [5];
    int          src_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int          cycles        = 0;

    // Newest entry holding this data address, or -1
    function automatic int lookup_block(input logic [31:0] addr);
        int i;
        for (i = tbl_used - 1; i >= 0; i--)
            if (tbl_addr[i] == addr)
                return i;
        return -1;
    endfunction

    function automatic status_t model_grant(input logic [30:0] size, output logic [31:0] addr);
        int          i;
        logic [33:0] data_at;
        logic [33:0] end_at;
        addr = '0;
        if (size == 0)
            return ST_ZERO;
        for (i = tbl_used - 1; i >= 0; i--)
        begin
            if (tbl_free[i] && tbl_size[i] >= size)
            begin
                tbl_free[i] = 1'b0;
                addr = tbl_addr[i];
                return ST_OK;
            end
        end
        if (tbl_used >= TABLE_DEPTH)
            return ST_NOSPACE;
        // no wrap: the new top is compared at full width
        data_at = {2'b00, brk_ptr} + 34'(HEADER_SIZE);
        end_at  = data_at + {3'b000, size};
        if (end_at > {2'b00, cfg_limit})
            return ST_NOSPACE;
        tbl_addr[tbl_used] = data_at[31:0];
        tbl_size[tbl_used] = size;
        tbl_free[tbl_used] = 1'b0;
        tbl_used++;
        brk_ptr = end_at[31:0];
        addr = data_at[31:0];
        return ST_OK;
    endfunction

    function automatic res_t predict_request(input op_t op, input logic [30:0] size,
                                             input logic [30:0] cnt, input logic [31:0] addr);
        res_t        r;
        int          idx;
        logic [61:0] prod;
        logic [31:0] granted;
        r = '0;
        r.status = ST_OK;
        granted = '0;
        case (op)
            OP_ALLOC:
            begin
                r.status = model_grant(size, granted);
                r.result_address = granted;
            end
            OP_FREE:
            begin
                if (addr == 0)
                    r.status = ST_ZERO;
                else
                begin
                    idx = lookup_block(addr);
                    if (idx < 0)
                        r.status = ST_UNKNOWN;
                    else
                        tbl_free[idx] = 1'b1;
                end
            end
            OP_REALLOC:
            begin
                if (addr == 0)
                begin
                    r.status = model_grant(size, granted);
                    r.result_address = granted;
                end
                else
                begin
                    idx = lookup_block(addr);
                    if (idx < 0 || tbl_free[idx])
                        r.status = ST_UNKNOWN;
                    else if (size == 0)
                    begin
                        tbl_free[idx] = 1'b1;
                        r.status = ST_ZERO;
                    end
                    else if (tbl_size[idx] >= size)
                        r.result_address = addr;
                    else
                    begin
                        r.status = model_grant(size, granted);
                        r.result_address = granted;
                        if (r.status == ST_OK)
                        begin
                            r.copy_bytes = tbl_size[idx];
                            r.released_address = addr;
                            tbl_free[idx] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                if (cnt == 0 || size == 0)
                    r.status = ST_ZERO;
                else
                begin
                    prod = 62'(cnt) * 62'(size);
                    if (prod > 62'(SIZE_CAP))
                        r.status = ST_OVERFLOW;
                    else
                    begin
                        r.status = model_grant(prod[30:0], granted);
                        r.result_address = granted;
                    end
                end
            end
        endcase
        if (r.status != ST_OK)
        begin
            r.result_address   = '0;
            r.copy_bytes       = '0;
            r.released_address = '0;
        end
        return r;
    endfunction

    function automatic logic [31:0] room_above_top(input logic [31:0] span);
        if (brk_ptr > ADDR_MAX - span)
            return ADDR_MAX;
        return brk_ptr + span;
    endfunction

    // Hold valid high across back-to-back transfers; quiesce() drops it
    task automatic send_request(input op_t op, input logic [30:0] size, input logic [30:0] cnt,
                                input logic [31:0] addr, output res_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, addr, cnt, size};
        do
            @(posedge clk);
        while (!s_axis_tready);
        want = predict_request(op, size, cnt, addr);
        pending_results.push_back(want);
        requests_sent++;
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == CFG_HEAP_BASE)
        begin
            cfg_base = value;
            if (tbl_used == 0)
                brk_ptr = value;
        end
        else if (index == CFG_HEAP_LIMIT)
            cfg_limit = value;
    endtask

    // Drop both valids and hold until every expected result has come back
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    task automatic retune_heap(input logic [31:0] base, input logic [31:0] limit);
        quiesce();
        write_reg(CFG_HEAP_BASE, base);
        write_reg(CFG_HEAP_LIMIT, limit);
        quiesce();
        settings_used++;
    endtask

    function automatic logic [30:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 11)
            return 31'($urandom);
        return 31'($urandom_range(256, 1));
    endfunction

    function automatic logic [31:0] pick_block_address();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80 && tbl_used > 0)
            return tbl_addr[$urandom_range(tbl_used - 1)];
        if (roll < 88)
            return '0;
        return $urandom;
    endfunction

    task automatic test_config_edges();
        res_t r;
        quiesce();
        write_reg(CFG_HEAP_LIMIT, '0);
        quiesce();
        send_request(OP_ALLOC, 31'd8, '0, '0, r);
        quiesce();
        write_reg(CFG_HEAP_LIMIT, ADDR_MAX);
        write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF0);
        quiesce();
        // the new top would wrap past the limit
        send_request(OP_ALLOC, 31'd1, SIZE_MAX, ADDR_MAX, r);
        quiesce();
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        quiesce();
        send_request(OP_ALLOC, 31'd1, '0, '0, r);
        quiesce();
        write_reg(CFG_HEAP_BASE, '0);
        quiesce();
    endtask

    task automatic test_rejects();
        res_t r;
        send_request(OP_ALLOC, '0, SIZE_MAX, ADDR_MAX, r);
        send_request(OP_FREE, '0, '0, '0, r);
        send_request(OP_FREE, SIZE_MAX, '0, ADDR_MAX, r);
        send_request(OP_REALLOC, 31'd4, '0, ADDR_MAX, r);
        send_request(OP_CALLOC, 31'd8, '0, '0, r);
        send_request(OP_CALLOC, '0, 31'd8, '0, r);
        send_request(OP_CALLOC, SIZE_MAX, SIZE_MAX, '0, r);
        // product one above the size cap
        send_request(OP_CALLOC, 31'h8000, 31'h10000, '0, r);
        quiesce();
    endtask

    task automatic test_grant_and_reuse();
        res_t        r;
        logic [31:0] blk_a;
        logic [31:0] blk_b;
        logic [31:0] blk_c;
        send_request(OP_ALLOC, 31'd100, '0, '0, r);
        blk_a = r.result_address;
        send_request(OP_ALLOC, 31'd40, '0, '0, r);
        blk_b = r.result_address;
        quiesce();
        // table is not empty, so the top must stay put
        write_reg(CFG_HEAP_BASE, 32'h0000_5000);
        quiesce();
        send_request(OP_ALLOC, 31'd16, '0, '0, r);
        blk_c = r.result_address;
        send_request(OP_REALLOC, 31'd50, '0, blk_a, r);
        send_request(OP_REALLOC, 31'd200, '0, blk_b, r);
        send_request(OP_FREE, '0, '0, blk_a, r);
        send_request(OP_FREE, '0, '0, blk_a, r);
        send_request(OP_REALLOC, 31'd8, '0, blk_a, r);
        send_request(OP_ALLOC, 31'd60, '0, '0, r);
        send_request(OP_REALLOC, 31'd30, '0, '0, r);
        send_request(OP_REALLOC, '0, '0, blk_c, r);
        send_request(OP_CALLOC, 31'd5, 31'd3, '0, r);
        quiesce();
    endtask

    task automatic test_realloc_no_room();
        res_t        r;
        logic [31:0] blk_d;
        send_request(OP_ALLOC, 31'd8, '0, '0, r);
        blk_d = r.result_address;
        quiesce();
        write_reg(CFG_HEAP_LIMIT, brk_ptr);
        quiesce();
        send_request(OP_REALLOC, 31'd5000, '0, blk_d, r);
        send_request(OP_ALLOC, 31'd5000, '0, '0, r);
        quiesce();
        write_reg(CFG_HEAP_LIMIT, ADDR_MAX);
        quiesce();
    endtask

    task automatic test_large_requests();
        res_t        r;
        logic [31:0] blk_e;
        send_request(OP_ALLOC, SIZE_MAX, '0, '0, r);
        blk_e = r.result_address;
        send_request(OP_REALLOC, SIZE_MAX, '0, blk_e, r);
        send_request(OP_CALLOC, SIZE_MAX, 31'd1, '0, r);
        send_request(OP_FREE, '0, '0, blk_e, r);
        quiesce();
    endtask

    task automatic test_random_traffic(input int items, input int src_pct, input int rcv_pct);
        res_t        r;
        op_t         op;
        int          n;
        int          roll;
        int          shape;
        logic [30:0] size;
        logic [30:0] cnt;
        logic [31:0] addr;
        src_idle_pct  = src_pct;
        rcv_stall_pct = rcv_pct;
        for (n = 0; n < items; n++)
        begin
            roll = $urandom_range(99);
            size = pick_size();
            cnt  = 31'($urandom);
            addr = $urandom;
            if (roll < 30)
                op = OP_ALLOC;
            else if (roll < 50)
            begin
                op = OP_FREE;
                addr = pick_block_address();
            end
            else if (roll < 78)
            begin
                op = OP_REALLOC;
                addr = pick_block_address();
            end
            else
            begin
                op = OP_CALLOC;
                shape = $urandom_range(9);
                if (shape == 0)
                begin
                    if ($urandom_range(1) == 0)
                        cnt = '0;
                    else
                        size = '0;
                end
                else if (shape == 1)
                    size = 31'($urandom);
                else
                begin
                    cnt  = 31'($urandom_range(16, 1));
                    size = 31'($urandom_range(64, 1));
                end
            end
            send_request(op, size, cnt, addr, r);
            if ($urandom_range(39) == 0)
                quiesce();
        end
        quiesce();
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        res_t want;
        res_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.status           = status_t'(m_axis_tuser);
            got.result_address   = m_axis_tdata[31:0];
            got.copy_bytes       = m_axis_tdata[62:32];
            got.released_address = m_axis_tdata[94:63];
            if (m_axis_tuser < 3'd5)
                status_seen[m_axis_tuser]++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d addr %h",
                         $time, m_axis_tuser, got.result_address);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                report_field("status", 32'(want.status), 32'(got.status));
                report_field("result_address", want.result_address, got.result_address);
                report_field("copy_bytes", 32'(want.copy_bytes), 32'(got.copy_bytes));
                report_field("released_address", want.released_address,
                             got.released_address);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_config_edges();
        test_rejects();
        test_grant_and_reuse();
        test_realloc_no_room();
        test_large_requests();

        retune_heap(ADDR_MAX, room_above_top(32'd6000));
        test_random_traffic(PHASE_ITEMS, 0, 0);
        retune_heap('0, ADDR_MAX);
        test_random_traffic(PHASE_ITEMS, 59, 0);
        retune_heap($urandom, room_above_top(32'd20000));
        test_random_traffic(PHASE_ITEMS, 0, 59);
        retune_heap(HEAP_BASE_RST, ADDR_MAX);
        test_random_traffic(PHASE_ITEMS, 20, 20);

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests under %0d heap settings; %0d of %0d table entries in use.",
                 requests_sent, settings_used, tbl_used, TABLE_DEPTH);
        $display("Results: ok %0d, zero %0d, no space %0d, overflow %0d, unknown %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
